@@ hw/rtl/itoa_pkg.sv @@
// Package for the integer to ASCII formatter: item types, base mode codes,
// ASCII constants and the digit to character mapping.
// No dependencies.
`default_nettype none

package itoa_pkg;

    // Base mode codes carried in the input item.
    localparam logic [1:0] MODE_DEC       = 2'd0;
    localparam logic [1:0] MODE_OCT       = 2'd1;
    localparam logic [1:0] MODE_HEX_UPPER = 2'd2;
    localparam logic [1:0] MODE_HEX_LOWER = 2'd3;

    // ASCII characters used by the formatter.
    localparam logic [7:0] ASCII_MINUS   = 8'h2D;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_NINE    = 8'h39;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_F = 8'h46;
    localparam logic [7:0] ASCII_LOWER_A = 8'h61;
    localparam logic [7:0] ASCII_LOWER_F = 8'h66;

    // One input item.
    typedef struct packed {
        logic [1:0]  mode;
        logic        is_signed;
        logic [63:0] value;
    } itoa_in_t;

    // One result item: a single character of the number text.
    typedef struct packed {
        logic [7:0] character;
        logic       last;
    } itoa_out_t;

    // Map one digit value to its ASCII character, in upper or lower case.
    function automatic logic [7:0] digit_char(input logic [3:0] d, input logic lower);
        logic [7:0] letter_base;
        letter_base = lower ? ASCII_LOWER_A : ASCII_UPPER_A;
        if (d < 4'd10) begin
            return ASCII_ZERO + {4'b0000, d};
        end else begin
            return letter_base + {4'b0000, d} - 8'd10;
        end
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/integer_to_ascii_formatter.sv @@
// Integer to ASCII formatter top level: sequencer, shift-and-add-3 BCD
// converter, digit shift register and output register.
// Depends on itoa_pkg.
// One item at a time. A decimal item is accepted, converted one value bit at a time
// by the shared BCD adjust unit, stripped of leading zero digits, given its sign
// step and then emitted digit by digit, each character waiting for a free output
// register. Octal and hex skip the conversion.
// Reset (aresetn, synchronous, active low) returns the sequencer to idle and
// empties the output register.
`default_nettype none

module integer_to_ascii_formatter
    import itoa_pkg::*;
#(
    parameter int VALUE_WIDTH = 64
) (
    input  wire logic      aclk,
    input  wire logic      aresetn,
    input  wire logic      s_valid,
    output logic           s_ready,
    input  wire itoa_in_t  s_data,
    output logic           m_valid,
    input  wire logic      m_ready,
    output itoa_out_t      m_data
);

    // Digit buffer sizing: enough digits for decimal and for octal.
    localparam int DEC_DIGITS = (VALUE_WIDTH * 30103) / 100000 + 1;
    localparam int OCT_DIGITS = (VALUE_WIDTH + 2) / 3;
    localparam int NDIG       = (DEC_DIGITS > OCT_DIGITS) ? DEC_DIGITS : OCT_DIGITS;
    localparam int DW         = NDIG * 4;
    localparam int RW         = $clog2(NDIG + 1);
    localparam int CW         = $clog2(VALUE_WIDTH + 1);

    // Sequencer states.
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_CONV = 3'd1;
    localparam logic [2:0] ST_SKIP = 3'd2;
    localparam logic [2:0] ST_SIGN = 3'd3;
    localparam logic [2:0] ST_EMIT = 3'd4;

    logic [2:0]             state_reg, state_next;
    logic [VALUE_WIDTH-1:0] mag_reg, mag_next;
    logic [DW-1:0]          dig_reg, dig_next;
    logic [RW-1:0]          rem_reg, rem_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic                   neg_reg, neg_next;
    logic                   lower_reg, lower_next;
    logic                   m_valid_reg, m_valid_next;
    itoa_out_t              m_data_reg, m_data_next;

    logic [VALUE_WIDTH-1:0] in_raw;
    logic                   in_neg;
    logic [VALUE_WIDTH-1:0] in_mag;
    logic [DW-1:0]          in_wide;
    logic [DW-1:0]          oct_pack;
    logic [DW-1:0]          hex_pack;
    logic [DW-1:0]          bcd_adj;
    logic [DW-1:0]          bcd_shift;
    logic [3:0]             top_digit;
    logic                   slot_free;

    // Magnitude of the incoming value, negated when signed and negative.
    assign in_raw  = s_data.value[VALUE_WIDTH-1:0];
    assign in_neg  = s_data.is_signed & in_raw[VALUE_WIDTH-1];
    assign in_mag  = in_neg ? (~in_raw + 1'b1) : in_raw;
    assign in_wide = DW'(in_mag);

    // Octal and hex digits are plain bit groups of the magnitude.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            oct_pack[4*i +: 4] = {1'b0, in_wide[3*i +: 3]};
            hex_pack[4*i +: 4] = in_wide[4*i +: 4];
        end
    end

    // Shared BCD unit: add 3 to every digit of 5 or more, then shift in one bit.
    always_comb begin
        for (int i = 0; i < NDIG; i++) begin
            bcd_adj[4*i +: 4] = (dig_reg[4*i +: 4] >= 4'd5) ?
                                (dig_reg[4*i +: 4] + 4'd3) : dig_reg[4*i +: 4];
        end
    end
    assign bcd_shift = {bcd_adj[DW-2:0], mag_reg[VALUE_WIDTH-1]};

    assign top_digit = dig_reg[DW-1 -: 4];
    assign slot_free = !m_valid_reg || m_ready;

    // Sequencer and output register next state.
    always_comb begin
        state_next   = state_reg;
        mag_next     = mag_reg;
        dig_next     = dig_reg;
        rem_next     = rem_reg;
        cnt_next     = cnt_reg;
        neg_next     = neg_reg;
        lower_next   = lower_reg;
        m_valid_next = m_valid_reg && !m_ready;
        m_data_next  = m_data_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    neg_next   = in_neg;
                    lower_next = (s_data.mode == MODE_HEX_LOWER);
                    rem_next   = RW'(NDIG);
                    mag_next   = in_mag;
                    if (s_data.mode == MODE_DEC) begin
                        dig_next   = '0;
                        cnt_next   = CW'(VALUE_WIDTH);
                        state_next = ST_CONV;
                    end else begin
                        dig_next   = (s_data.mode == MODE_OCT) ? oct_pack : hex_pack;
                        state_next = ST_SKIP;
                    end
                end
            end
            ST_CONV: begin
                dig_next = bcd_shift;
                mag_next = {mag_reg[VALUE_WIDTH-2:0], 1'b0};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    state_next = ST_SKIP;
                end
            end
            ST_SKIP: begin
                // Drop leading zeros, keeping at least one digit.
                if (top_digit == 4'd0 && rem_reg > RW'(1)) begin
                    dig_next = {dig_reg[DW-5:0], 4'b0000};
                    rem_next = rem_reg - 1'b1;
                end else begin
                    state_next = ST_SIGN;
                end
            end
            ST_SIGN: begin
                if (!neg_reg) begin
                    state_next = ST_EMIT;
                end else if (slot_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.character = ASCII_MINUS;
                    m_data_next.last      = 1'b0;
                    state_next            = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next          = 1'b1;
                    m_data_next.character = digit_char(top_digit, lower_reg);
                    m_data_next.last      = (rem_reg == RW'(1));
                    dig_next              = {dig_reg[DW-5:0], 4'b0000};
                    rem_next              = rem_reg - 1'b1;
                    if (rem_reg == RW'(1)) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        mag_reg    <= mag_next;
        dig_reg    <= dig_next;
        rem_reg    <= rem_next;
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        lower_reg  <= lower_next;
        m_data_reg <= m_data_next;
    end

    assign s_ready = (state_reg == ST_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

`default_nettype wire

@@ hw/rtl/itoa_checker.sv @@
// Port-level checker for the integer to ASCII formatter, with its bind.
// Depends on itoa_pkg and integer_to_ascii_formatter.
`default_nettype none

module itoa_checker
    import itoa_pkg::*;
(
    input wire logic      aclk,
    input wire logic      aresetn,
    input wire logic      s_valid,
    input wire logic      s_ready,
    input wire itoa_in_t  s_data,
    input wire logic      m_valid,
    input wire logic      m_ready,
    input wire itoa_out_t m_data
);

    // A stalled result item holds its place and value.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result item changed while stalled");

    // The block takes one item at a time.
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken again right after an accept");

    // Every character is a sign or a digit of some base.
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.character == ASCII_MINUS) ||
                    (m_data.character >= ASCII_ZERO && m_data.character <= ASCII_NINE) ||
                    (m_data.character >= ASCII_UPPER_A &&
                     m_data.character <= ASCII_UPPER_F) ||
                    (m_data.character >= ASCII_LOWER_A &&
                     m_data.character <= ASCII_LOWER_F))
        else $error("character outside the number alphabet");

    // A minus sign is always followed by digits.
    a_sign_not_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_data.character == ASCII_MINUS) |-> !m_data.last)
        else $error("minus sign marked as last character");

endmodule

bind integer_to_ascii_formatter itoa_checker u_itoa_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_data  (s_data),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

`default_nettype wire

@@ tb/tb_integer_to_ascii_formatter.sv @@
// Self-checking testbench for the integer to ASCII formatter: directed and random numbers
// in every base, with random sender gaps and receiver stalls, checked character by character.
// Depends on itoa_pkg and integer_to_ascii_formatter.

module tb_integer_to_ascii_formatter
    import itoa_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int VALUE_WIDTH    = 64;
    localparam int RANDOM_NUMBERS = 360;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 200;

    // Digit glyphs; the first character of each string sits in the top byte.
    localparam logic [8*16-1:0] UPPER_GLYPHS = "0123456789ABCDEF";
    localparam logic [8*16-1:0] LOWER_GLYPHS = "0123456789abcdef";

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    itoa_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    itoa_out_t m_data;

    itoa_in_t  pending_numbers[$];
    itoa_out_t expected_chars[$];

    int mismatch_count = 0;
    int numbers_sent = 0;
    int negatives_sent = 0;
    int chars_checked = 0;
    int longest_text = 0;
    int burst_left = 0;
    int gap_left = 0;
    int idle_cycles = 0;
    int unsigned pattern_cycle = 0;

    integer_to_ascii_formatter #(
        .VALUE_WIDTH(VALUE_WIDTH)
    ) dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Print one line per mismatch and count it.
    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Work out the text of one number and queue its characters; returns the text length.
    function automatic int predict_text(input itoa_in_t number);
        logic [63:0] width_mask;
        logic [63:0] sign_bit;
        logic [63:0] magnitude;
        logic [63:0] radix;
        logic [3:0]  digit;
        logic        negative;
        logic [7:0]  glyphs[$];
        itoa_out_t   ch;
        width_mask = {64{1'b1}} >> (64 - VALUE_WIDTH);
        sign_bit   = 64'd1 << (VALUE_WIDTH - 1);
        magnitude  = number.value & width_mask;
        negative   = number.is_signed && ((magnitude & sign_bit) != 64'd0);
        if (negative) begin
            magnitude = (~magnitude + 64'd1) & width_mask;
        end
        case (number.mode)
            MODE_DEC: radix = 64'd10;
            MODE_OCT: radix = 64'd8;
            default:  radix = 64'd16;
        endcase
        // Peel digits off the low end, so each new one goes to the front.
        do begin
            digit = 4'(magnitude % radix);
            if (number.mode == MODE_HEX_LOWER) begin
                glyphs.push_front(LOWER_GLYPHS[(15 - digit) * 8 +: 8]);
            end else begin
                glyphs.push_front(UPPER_GLYPHS[(15 - digit) * 8 +: 8]);
            end
            magnitude = magnitude / radix;
        end while (magnitude != 64'd0);
        if (negative) begin
            ch.character = ASCII_MINUS;
            ch.last = 1'b0;
            expected_chars.push_back(ch);
        end
        foreach (glyphs[i]) begin
            ch.character = glyphs[i];
            ch.last = (i == glyphs.size() - 1);
            expected_chars.push_back(ch);
        end
        return glyphs.size() + (negative ? 1 : 0);
    endfunction

    function automatic itoa_in_t make_number(input logic [1:0] mode, input logic sgn,
                                             input logic [63:0] value);
        itoa_in_t number;
        number.mode = mode;
        number.is_signed = sgn;
        number.value = value;
        return number;
    endfunction

    // Random numbers in several shapes so that every text length and sign case shows up.
    function automatic itoa_in_t random_number();
        logic [63:0] raw;
        logic [63:0] low;
        int unsigned len;
        raw = {$urandom, $urandom};
        low = 64'($urandom_range(0, 999));
        len = $urandom_range(1, 64);
        case ($urandom_range(0, 4))
            0: ;
            1: raw = low;
            2: raw = raw & ({64{1'b1}} >> (64 - len));
            3: raw = ~low + 64'd1;
            default: raw = $urandom_range(0, 1) ? {1'b1, 63'(low)}
                                                  : 64'h7FFF_FFFF_FFFF_FFFF - low;
        endcase
        return make_number(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)), raw);
    endfunction

    // Sender: bursts of items with random gaps, holding each item until it is taken.
    always @(posedge aclk) begin : sender
        int text_len;
        if (!aresetn) begin
            s_valid <= 1'b0;
            burst_left = $urandom_range(1, 16);
            gap_left = 0;
        end else begin
            if (s_valid && s_ready) begin
                text_len = predict_text(pending_numbers.pop_front());
                numbers_sent++;
                if (expected_chars[expected_chars.size() - text_len].character == ASCII_MINUS)
                begin
                    negatives_sent++;
                end
                if (text_len > longest_text) begin
                    longest_text = text_len;
                end
            end
            if (s_valid && !s_ready) begin
                // Item still waiting: keep valid and payload as they are.
            end else if (gap_left > 0) begin
                gap_left--;
                s_valid <= 1'b0;
            end else if (pending_numbers.size() != 0) begin
                s_valid <= 1'b1;
                s_data <= pending_numbers[0];
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 16);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
                end
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver: check each taken character and stall in a pattern that changes over time.
    always @(posedge aclk) begin : receiver
        itoa_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            pattern_cycle <= 0;
        end else begin
            if (m_valid && m_ready) begin
                chars_checked++;
                if (expected_chars.size() == 0) begin
                    report_mismatch($sformatf("unexpected character %h last %b",
                                              m_data.character, m_data.last));
                end else begin
                    want = expected_chars.pop_front();
                    if (m_data.character !== want.character) begin
                        report_mismatch($sformatf("character %h, expected %h",
                                                  m_data.character, want.character));
                    end
                    if (m_data.last !== want.last) begin
                        report_mismatch($sformatf("last %b on character %h, expected %b",
                                                  m_data.last, want.character, want.last));
                    end
                end
            end
            pattern_cycle <= pattern_cycle + 1;
            case ((pattern_cycle / 256) % 4)
                0: m_ready <= 1'b1;
                1: m_ready <= ($urandom_range(0, 3) != 0);
                2: m_ready <= ((pattern_cycle % 3) == 0);
                default: m_ready <= ($urandom_range(0, 3) == 0);
            endcase
        end
    end

    // Watchdog: end the run if no item moves on either channel for too long.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
            $display("end of test: mismatches");
            $finish;
        end
    end

    initial begin
        // Directed numbers: zeros, all ones, most negative, every digit glyph, short texts.
        pending_numbers.push_back(make_number(MODE_DEC, 1'b0, 64'd0));
        pending_numbers.push_back(make_number(MODE_OCT, 1'b0, 64'd0));
        pending_numbers.push_back(make_number(MODE_HEX_UPPER, 1'b0, 64'd0));
        pending_numbers.push_back(make_number(MODE_HEX_LOWER, 1'b1, 64'd0));
        pending_numbers.push_back(make_number(MODE_DEC, 1'b1, 64'd0));
        pending_numbers.push_back(make_number(MODE_DEC, 1'b0, {64{1'b1}}));
        pending_numbers.push_back(make_number(MODE_OCT, 1'b0, {64{1'b1}}));
        pending_numbers.push_back(make_number(MODE_HEX_UPPER, 1'b0, {64{1'b1}}));
        pending_numbers.push_back(make_number(MODE_HEX_LOWER, 1'b0, {64{1'b1}}));
        pending_numbers.push_back(make_number(MODE_DEC, 1'b1, 64'h8000_0000_0000_0000));
        pending_numbers.push_back(make_number(MODE_OCT, 1'b1, 64'h8000_0000_0000_0000));
        pending_numbers.push_back(make_number(MODE_HEX_UPPER, 1'b1, 64'h8000_0000_0000_0000));
        pending_numbers.push_back(make_number(MODE_HEX_LOWER, 1'b1, 64'h8000_0000_0000_0000));
        pending_numbers.push_back(make_number(MODE_DEC, 1'b1, {64{1'b1}}));
        pending_numbers.push_back(make_number(MODE_DEC, 1'b1, 64'h7FFF_FFFF_FFFF_FFFF));
        pending_numbers.push_back(make_number(MODE_DEC, 1'b0, 64'h8000_0000_0000_0000));
        pending_numbers.push_back(make_number(MODE_HEX_UPPER, 1'b0, 64'hFEDC_BA98_7654_3210));
        pending_numbers.push_back(make_number(MODE_HEX_LOWER, 1'b0, 64'hFEDC_BA98_7654_3210));
        pending_numbers.push_back(make_number(MODE_HEX_LOWER, 1'b1, 64'h0123_4567_89AB_CDEF));
        pending_numbers.push_back(make_number(MODE_OCT, 1'b1, 64'o1234567));
        pending_numbers.push_back(make_number(MODE_DEC, 1'b0, 64'd10));
        pending_numbers.push_back(make_number(MODE_DEC, 1'b1, 64'd9));
        pending_numbers.push_back(make_number(MODE_OCT, 1'b1, 64'hFFFF_FFFF_FFFF_FFF8));
        pending_numbers.push_back(make_number(MODE_HEX_LOWER, 1'b0, 64'd15));
        for (int i = 0; i < RANDOM_NUMBERS; i++) begin
            pending_numbers.push_back(random_number());
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Wait for every number to be taken and every character to arrive, then settle.
        while (pending_numbers.size() != 0 || s_valid || expected_chars.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("formatted %0d numbers (%0d negative) in all four bases, %0d characters checked,",
                 numbers_sent, negatives_sent, chars_checked);
        $display("longest text %0d characters, %0d mismatches", longest_text, mismatch_count);
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
